FILE: hdl/sem_pkg.sv
// shared constants and types of the sobel edge magnitude block
package sem_pkg;

    localparam int LINE_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 16;
    localparam int COL_W      = 12;
    localparam int MAG_W      = 11;
    localparam int GRAD_W     = PIX_W + 4;
    localparam int MAG_MAX    = 2047;
    localparam int MIN_DIM    = 3;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_LVL_W    = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix [2:0][2:0]       win;
        logic [HEIGHT_W-1:0]   row;
        logic [COL_W-1:0]      col;
        logic                  last;
    } t_win_entry;

    typedef struct packed {
        logic                  empty;
        logic [Q_LVL_W-1:0]    level;
    } t_q_status;

endpackage

FILE: hdl/sem_pix_if.sv
// pixel input channel
interface sem_pix_if;
    logic              valid;
    logic              ready;
    logic [sem_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

FILE: hdl/sem_res_if.sv
// edge magnitude result channel
interface sem_res_if;
    logic                         valid;
    logic                         ready;
    logic [sem_pkg::MAG_W-1:0]    magnitude;
    logic [sem_pkg::HEIGHT_W-1:0] out_row;
    logic [sem_pkg::COL_W-1:0]    out_col;
    logic                         frame_last;

    modport source (output valid, output magnitude, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input magnitude, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

FILE: hdl/sem_front.sv
// front end: pixel transfer, position tracking, line stores and 3x3 window
module sem_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sem_pix_if.sink                        i_pix,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  sem_pkg::t_q_status             i_q_status,
    output logic                           o_push,
    output sem_pkg::t_win_entry            o_entry
);

    logic [sem_pkg::WIDTH_W-1:0]  r_frame_width;
    logic [sem_pkg::HEIGHT_W-1:0] r_frame_height;
    logic [sem_pkg::HEIGHT_W-1:0] r_row;
    logic [sem_pkg::COL_W-1:0]    r_col;

    sem_pkg::t_pix r_mem_old [sem_pkg::LINE_DEPTH];
    sem_pkg::t_pix r_mem_new [sem_pkg::LINE_DEPTH];
    sem_pkg::t_pix r_old_rd;
    sem_pkg::t_pix r_new_rd;

    logic                         r_s1_valid;
    sem_pkg::t_pix                r_s1_pix;
    logic [sem_pkg::ADDR_W-1:0]   r_s1_idx;
    logic                         r_s1_res;
    logic [sem_pkg::HEIGHT_W-1:0] r_s1_row;
    logic [sem_pkg::COL_W-1:0]    r_s1_col;
    logic                         r_s1_last;
    logic                         r_s1_fwd;
    sem_pkg::t_pix                r_fwd_old;
    sem_pkg::t_pix                r_fwd_new;

    sem_pkg::t_pix [2:0][2:0]     r_win;
    sem_pkg::t_pix [2:0][2:0]     n_win;

    logic [sem_pkg::WIDTH_W-1:0]  w_eff;
    logic [sem_pkg::HEIGHT_W-1:0] h_eff;
    logic [sem_pkg::COL_W-1:0]    w_m1;
    logic [sem_pkg::HEIGHT_W-1:0] h_m1;
    logic [sem_pkg::COL_W-1:0]    col_cl;
    logic [sem_pkg::ADDR_W-1:0]   idx;
    logic                         acc;
    logic                         ready;
    logic                         has_res;
    logic                         is_last;
    logic                         end_of_line;
    logic [sem_pkg::HEIGHT_W-1:0] n_row;
    logic [sem_pkg::COL_W-1:0]    n_col;
    sem_pkg::t_pix                s1_old;
    sem_pkg::t_pix                s1_new;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sem_pkg::WIDTH_RST;
            r_frame_height <= sem_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (sem_pkg::t_cfg_idx'(i_cfg_index))
                sem_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_wdata[sem_pkg::WIDTH_W-1:0];
                end
                sem_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_wdata[sem_pkg::HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective frame size and position logic
    always_comb begin
        if (r_frame_width < sem_pkg::WIDTH_W'(sem_pkg::MIN_DIM)) begin
            w_eff = sem_pkg::WIDTH_W'(sem_pkg::MIN_DIM);
        end else if (r_frame_width > sem_pkg::WIDTH_W'(sem_pkg::LINE_DEPTH)) begin
            w_eff = sem_pkg::WIDTH_W'(sem_pkg::LINE_DEPTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height < sem_pkg::HEIGHT_W'(sem_pkg::MIN_DIM)) begin
            h_eff = sem_pkg::HEIGHT_W'(sem_pkg::MIN_DIM);
        end else begin
            h_eff = r_frame_height;
        end
        w_m1   = sem_pkg::COL_W'(w_eff - sem_pkg::WIDTH_W'(1));
        h_m1   = h_eff - sem_pkg::HEIGHT_W'(1);
        col_cl = ({1'b0, r_col} >= w_eff) ? w_m1 : r_col;
        idx    = sem_pkg::ADDR_W'(col_cl);

        has_res     = (r_row >= sem_pkg::HEIGHT_W'(2)) && (col_cl >= sem_pkg::COL_W'(2));
        end_of_line = (col_cl >= w_m1);
        is_last     = (r_row >= h_m1) && end_of_line;

        if (end_of_line) begin
            n_col = '0;
            n_row = (r_row >= h_m1) ? '0 : r_row + sem_pkg::HEIGHT_W'(1);
        end else begin
            n_col = col_cl + sem_pkg::COL_W'(1);
            n_row = r_row;
        end
    end

    // stall only when the queue could not take everything in flight
    assign ready = ((sem_pkg::Q_LVL_W + 1)'(i_q_status.level)
                  + (sem_pkg::Q_LVL_W + 1)'(r_s1_valid))
                  < (sem_pkg::Q_LVL_W + 1)'(sem_pkg::Q_DEPTH);
    assign i_pix.ready = ready;
    assign acc = i_pix.valid && ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // line stores: read on transfer, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_old_rd <= r_mem_old[idx];
        end
        if (r_s1_valid) begin
            r_mem_old[r_s1_idx] <= s1_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_new_rd <= r_mem_new[idx];
        end
        if (r_s1_valid) begin
            r_mem_new[r_s1_idx] <= r_s1_pix;
        end
    end

    // bypass when the same column is read back before its write lands
    assign s1_old = r_s1_fwd ? r_fwd_old : r_old_rd;
    assign s1_new = r_s1_fwd ? r_fwd_new : r_new_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix  <= i_pix.pixel;
            r_s1_idx  <= idx;
            r_s1_res  <= has_res;
            r_s1_row  <= r_row - sem_pkg::HEIGHT_W'(1);
            r_s1_col  <= col_cl - sem_pkg::COL_W'(1);
            r_s1_last <= is_last;
            r_s1_fwd  <= r_s1_valid && (r_s1_idx == idx);
            r_fwd_old <= s1_new;
            r_fwd_new <= r_s1_pix;
        end
    end

    // window shift
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = s1_old;
        n_win[1][2] = s1_new;
        n_win[2][2] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    assign o_push       = r_s1_valid && r_s1_res;
    assign o_entry.win  = n_win;
    assign o_entry.row  = r_s1_row;
    assign o_entry.col  = r_s1_col;
    assign o_entry.last = r_s1_last;

endmodule

FILE: hdl/sem_queue.sv
// short queue of windows between front and back end
module sem_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sem_pkg::t_win_entry i_entry,
    input  logic                i_pop,
    output sem_pkg::t_win_entry o_head,
    output sem_pkg::t_q_status  o_status
);

    sem_pkg::t_win_entry         r_slot [sem_pkg::Q_DEPTH];
    logic [sem_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [sem_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [sem_pkg::Q_LVL_W-1:0] r_level;
    logic [sem_pkg::Q_LVL_W-1:0] n_level;

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + sem_pkg::Q_LVL_W'(1);
        end else if (!i_push && i_pop) begin
            n_level = r_level - sem_pkg::Q_LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + sem_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + sem_pkg::Q_PTR_W'(1);
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head         = r_slot[r_rd_ptr];
    assign o_status.empty = (r_level == '0);
    assign o_status.level = r_level;

endmodule

FILE: hdl/sem_back.sv
// back end: sobel gradients, magnitude and output register
module sem_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sem_pkg::t_win_entry i_head,
    input  sem_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    sem_res_if.source           o_res
);

    typedef logic signed [sem_pkg::GRAD_W-1:0] t_grad;

    function automatic t_grad ext(input sem_pkg::t_pix p);
        return $signed({{(sem_pkg::GRAD_W - sem_pkg::PIX_W){1'b0}}, p});
    endfunction

    logic                          r_valid;
    logic [sem_pkg::MAG_W-1:0]     r_mag;
    logic [sem_pkg::HEIGHT_W-1:0]  r_row;
    logic [sem_pkg::COL_W-1:0]     r_col;
    logic                          r_last;

    t_grad                         gv;
    t_grad                         gh;
    logic [sem_pkg::GRAD_W-1:0]    abs_v;
    logic [sem_pkg::GRAD_W-1:0]    abs_h;
    logic [sem_pkg::GRAD_W-1:0]    sum;
    logic [sem_pkg::MAG_W-1:0]     mag;
    logic                          take;

    always_comb begin
        gv = (ext(i_head.win[0][0]) - ext(i_head.win[2][0]))
           + ((ext(i_head.win[0][1]) - ext(i_head.win[2][1])) <<< 1)
           + (ext(i_head.win[0][2]) - ext(i_head.win[2][2]));
        gh = (ext(i_head.win[0][0]) - ext(i_head.win[0][2]))
           + ((ext(i_head.win[1][0]) - ext(i_head.win[1][2])) <<< 1)
           + (ext(i_head.win[2][0]) - ext(i_head.win[2][2]));
        abs_v = gv[sem_pkg::GRAD_W-1] ? $unsigned(-gv) : $unsigned(gv);
        abs_h = gh[sem_pkg::GRAD_W-1] ? $unsigned(-gh) : $unsigned(gh);
        sum   = abs_v + abs_h;
        mag   = (sum > sem_pkg::GRAD_W'(sem_pkg::MAG_MAX))
              ? sem_pkg::MAG_W'(sem_pkg::MAG_MAX) : sem_pkg::MAG_W'(sum);
    end

    assign take  = !i_q_status.empty && (!r_valid || o_res.ready);
    assign o_pop = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mag  <= mag;
            r_row  <= i_head.row;
            r_col  <= i_head.col;
            r_last <= i_head.last;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.magnitude  = r_mag;
    assign o_res.out_row    = r_row;
    assign o_res.out_col    = r_col;
    assign o_res.frame_last = r_last;

endmodule

FILE: hdl/sobel_edge_magnitude_unit.sv
// top level of the sobel edge magnitude block
// result path: pixel transfer, line store read register, window queue write, then output register
// throughput: one pixel per cycle; input stalls only when the 4-entry window queue backs up
// reset: synchronous active low; clears positions, window, queue and output control,
// frame size returns to 640 x 480; line stores are not cleared and hold old data
module sobel_edge_magnitude_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sem_pix_if.sink                        i_pix,
    sem_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    logic                q_push;
    logic                q_pop;
    sem_pkg::t_win_entry q_entry;
    sem_pkg::t_win_entry q_head;
    sem_pkg::t_q_status  q_status;

    sem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_status  (q_status),
        .o_push      (q_push),
        .o_entry     (q_entry)
    );

    sem_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_entry),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    sem_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .o_res      (o_res)
    );

    a_q_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= sem_pkg::Q_LVL_W'(sem_pkg::Q_DEPTH))
        else $error("window queue level beyond depth");

    a_q_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push && (q_status.level == sem_pkg::Q_LVL_W'(sem_pkg::Q_DEPTH)) |-> q_pop)
        else $error("window queue written while full");

    a_q_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("window queue read while empty");

    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.out_row != '0) && (o_res.out_col != '0))
        else $error("result for a border pixel");

endmodule
